FILE: rtl/lcc_pkg.sv
// Shared types, constants and helper functions for the Luhn card number classifier.
package lcc_pkg;

    localparam int unsigned MAX_DIGITS_DEFAULT = 16;
    localparam int unsigned VISA_LEN_SHORT = 13;
    localparam int unsigned VISA_LEN_LONG = 16;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef logic [3:0] digit_t;

    typedef enum logic [1:0] {
        VERDICT_INVALID    = 2'd0,
        VERDICT_AMEX       = 2'd1,
        VERDICT_MASTERCARD = 2'd2,
        VERDICT_VISA       = 2'd3
    } verdict_t;

    // One character of the number as it moves from the input register to the accumulator.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } lcc_item_t;

    // Doubled Luhn digit: 2d below ten, otherwise 2d minus nine.
    function automatic digit_t luhn_double(input digit_t d);
        logic [4:0] t;
        begin
            t = {d, 1'b0};
            luhn_double = (t < 5'd10) ? t[3:0] : 4'(t - 5'd9);
        end
    endfunction

    // Sum of two values in 0..9, reduced mod ten.
    function automatic digit_t add_mod10(input digit_t a, input digit_t b);
        logic [4:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            add_mod10 = (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
        end
    endfunction

endpackage

FILE: rtl/lcc_accum.sv
// Running Luhn sums, digit count and prefix capture, with the end-of-number verdict.
module lcc_accum
    import lcc_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  lcc_item_t item,
    output verdict_t  verdict
);

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

    logic [CNT_W-1:0] digit_count_reg, digit_count_next;
    digit_t           sum_even_reg, sum_even_next;
    digit_t           sum_odd_reg, sum_odd_next;
    digit_t           first_digit_reg, first_digit_next;
    digit_t           second_digit_reg, second_digit_next;
    logic             bad_input_reg, bad_input_next;

    logic   is_digit;
    logic   has_room;
    digit_t d;
    digit_t dd;
    digit_t sum_sel;

    always_comb
    begin
        is_digit = (item.char_code >= ASCII_ZERO) && (item.char_code <= ASCII_NINE);
        has_room = 32'(digit_count_reg) < 32'(MAX_DIGITS);
        d        = 4'(item.char_code - ASCII_ZERO);
        dd       = luhn_double(d);

        digit_count_next  = digit_count_reg;
        sum_even_next     = sum_even_reg;
        sum_odd_next      = sum_odd_reg;
        first_digit_next  = first_digit_reg;
        second_digit_next = second_digit_reg;
        bad_input_next    = bad_input_reg;

        if (!is_digit || !has_room)
        begin
            bad_input_next = 1'b1;
        end
        else
        begin
            if (!digit_count_reg[0])
            begin
                sum_even_next = add_mod10(sum_even_reg, dd);
                sum_odd_next  = add_mod10(sum_odd_reg, d);
            end
            else
            begin
                sum_even_next = add_mod10(sum_even_reg, d);
                sum_odd_next  = add_mod10(sum_odd_reg, dd);
            end
            if (digit_count_reg == '0)
            begin
                first_digit_next = d;
            end
            else if (digit_count_reg == CNT_W'(1))
            begin
                second_digit_next = d;
            end
            digit_count_next = digit_count_reg + CNT_W'(1);
        end

        // The verdict looks at the state including this character.
        sum_sel = digit_count_next[0] ? sum_odd_next : sum_even_next;
        if (bad_input_next || (sum_sel != 4'd0))
        begin
            verdict = VERDICT_INVALID;
        end
        else if ((first_digit_next == 4'd3)
                 && ((second_digit_next == 4'd4) || (second_digit_next == 4'd7)))
        begin
            verdict = VERDICT_AMEX;
        end
        else if ((first_digit_next == 4'd5)
                 && (second_digit_next >= 4'd1) && (second_digit_next <= 4'd5))
        begin
            verdict = VERDICT_MASTERCARD;
        end
        else if ((first_digit_next == 4'd4)
                 && ((32'(digit_count_next) == VISA_LEN_SHORT)
                     || (32'(digit_count_next) == VISA_LEN_LONG)))
        begin
            verdict = VERDICT_VISA;
        end
        else
        begin
            verdict = VERDICT_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= '0;
            sum_even_reg     <= '0;
            sum_odd_reg      <= '0;
            first_digit_reg  <= '0;
            second_digit_reg <= '0;
            bad_input_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_char)
            begin
                digit_count_reg  <= '0;
                sum_even_reg     <= '0;
                sum_odd_reg      <= '0;
                first_digit_reg  <= '0;
                second_digit_reg <= '0;
                bad_input_reg    <= 1'b0;
            end
            else
            begin
                digit_count_reg  <= digit_count_next;
                sum_even_reg     <= sum_even_next;
                sum_odd_reg      <= sum_odd_next;
                first_digit_reg  <= first_digit_next;
                second_digit_reg <= second_digit_next;
                bad_input_reg    <= bad_input_next;
            end
        end
    end

endmodule

FILE: rtl/luhn_card_number_classifier.sv
// Top level of the Luhn card number classifier: input register, accumulator, result register.
//
//   Channel   Direction  tdata (low bit up)            tlast         Transfer
//   s_axis    in         char_code[7:0]                last_char     one ASCII character
//   m_axis    out        verdict[1:0], zeros to bit 7  (none)        one verdict per number
//
// One character is taken in every cycle while s_axis_tready is high. A character waits in
// the input register until it advances; the accumulator then folds it into the running sums
// and, for a final character, the verdict is loaded into the result register, so a verdict
// passes through the input register and the result register before it is offered.
// Reset clears both valid flags and all accumulator state. A waiting verdict only holds
// back a following final character; other characters keep flowing while m_axis stalls.
module luhn_card_number_classifier
    import lcc_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // last_char

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] verdict, [7:2] zero
);

    logic      in_valid_reg;
    lcc_item_t in_item_reg;
    logic      out_valid_reg, out_valid_next;
    verdict_t  verdict_reg;
    verdict_t  verdict_now;
    logic      advance;

    // The held character moves on unless it is a final one and the result slot is full and not being taken.
    assign advance       = in_valid_reg
                           && (!in_item_reg.last_char || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.char_code <= s_axis_tdata;
            in_item_reg.last_char <= s_axis_tlast;
        end
    end

    lcc_accum #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (in_item_reg),
        .verdict (verdict_now)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance && in_item_reg.last_char)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_char)
        begin
            verdict_reg <= verdict_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, verdict_reg};

endmodule
